### src/rrsa_pkg.sv
`default_nettype none

package rrsa_pkg;

  // request and result field widths
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned LOAD_W   = 30;
  localparam int unsigned FINISH_W = 32;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned SRV_W    = 4;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned CFG_W    = 5;

  // saturation point of the per-server request count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // server count after reset, and default pool size
  localparam logic [CFG_W-1:0] CFG_RESET       = CFG_W'(16);
  localparam int unsigned      NUM_SERVERS_DEF = 16;

endpackage

`default_nettype wire

### src/round_robin_server_allocator.sv
// path: input register, allocation result register, output register
// throughput: one request per cycle unless out_stall holds the pipe; the allocation
// stage updates finish times and counts at the same edge that it passes the request
// on, so the next request sees them; reset: synchronous, active low; clears finish
// times, counts, rotation pointer and pipeline valids, and sets the server count to 16
`default_nettype none

module round_robin_server_allocator #(
  parameter int unsigned NUM_SERVERS = rrsa_pkg::NUM_SERVERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [rrsa_pkg::CFG_W-1:0]    cfg_wr_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rrsa_pkg::TIME_W-1:0]   in_arrival_time,
  input  wire logic [rrsa_pkg::LOAD_W-1:0]   in_service_load,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_dropped,
  output logic [rrsa_pkg::SRV_W-1:0]         out_assigned_server,
  output logic [rrsa_pkg::COUNT_W-1:0]       out_assigned_count,
  output logic [rrsa_pkg::COUNT_W-1:0]       out_busiest_count,
  output logic [rrsa_pkg::MASK_W-1:0]        out_busiest_mask
);

  import rrsa_pkg::*;

  localparam int unsigned IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int unsigned NK_W  = $clog2(NUM_SERVERS + 1);
  // wide enough for both the register value and the pool size
  localparam int unsigned KW    = (NK_W > CFG_W) ? NK_W : CFG_W;

  // configuration and rotation state
  logic [CFG_W-1:0]    srv_cfg_r;
  logic [IDX_W-1:0]    pref_r;
  logic [IDX_W-1:0]    pref_nxt;

  // per-server busy timers and request counts
  logic [FINISH_W-1:0] finish_r   [NUM_SERVERS];
  logic [FINISH_W-1:0] finish_nxt [NUM_SERVERS];
  logic [COUNT_W-1:0]  count_r    [NUM_SERVERS];
  logic [COUNT_W-1:0]  count_nxt  [NUM_SERVERS];

  // input register
  logic                s1_v_r;
  logic [TIME_W-1:0]   s1_time_r;
  logic [LOAD_W-1:0]   s1_load_r;

  // allocation result register
  logic                s2_v_r;
  logic                s2_drop_r;
  logic [SRV_W-1:0]    s2_srv_r;
  logic [COUNT_W-1:0]  s2_cnt_r;

  // output register
  logic                out_v_r;
  logic                out_drop_r;
  logic [SRV_W-1:0]    out_srv_r;
  logic [COUNT_W-1:0]  out_cnt_r;
  logic [COUNT_W-1:0]  out_best_r;
  logic [MASK_W-1:0]   out_mask_r;

  // handshake
  logic out_adv;
  logic s2_adv;
  logic s1_adv;
  logic in_fire;
  logic alloc_fire;

  // allocation datapath
  logic [KW-1:0]          k_raw;
  logic [KW-1:0]          k_n;
  logic [NUM_SERVERS-1:0] in_use;
  logic [NUM_SERVERS-1:0] free;
  logic [IDX_W-1:0]       pref_eff;
  logic [KW-1:0]          pref_inc;
  logic                   found;
  logic [NUM_SERVERS-1:0] pick_oh;
  logic [IDX_W-1:0]       pick_idx;
  logic [FINISH_W-1:0]    finish_new;
  logic [COUNT_W-1:0]     cnt_sel;
  logic [COUNT_W-1:0]     cnt_bump;
  logic [COUNT_W-1:0]     best;
  logic [MASK_W-1:0]      best_mask;

  // a stage moves on when the one after it is empty or moving too
  assign out_adv    = !out_v_r || !out_stall;
  assign s2_adv     = !s2_v_r || out_adv;
  assign s1_adv     = !s1_v_r || s2_adv;
  assign in_stall   = !s1_adv;
  assign in_fire    = in_valid && !in_stall;
  assign alloc_fire = s1_v_r && s1_adv;

  // effective server count: zero reads as one, too many reads as the pool size
  assign k_raw = KW'(srv_cfg_r);
  always_comb begin
    if (k_raw == '0) begin
      k_n = KW'(1);
    end else if (k_raw > KW'(NUM_SERVERS)) begin
      k_n = KW'(NUM_SERVERS);
    end else begin
      k_n = k_raw;
    end
  end

  // a stale pointer from before a server count change restarts at zero
  assign pref_eff = (KW'(pref_r) < k_n) ? pref_r : '0;
  assign pref_inc = KW'(pref_eff) + KW'(1);
  assign pref_nxt = (pref_inc >= k_n) ? '0 : IDX_W'(pref_inc);

  // free test against the arrival time, only servers in the rotation
  always_comb begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      in_use[s] = (KW'(s) < k_n);
      free[s]   = in_use[s] && (finish_r[s] <= FINISH_W'(s1_time_r));
    end
  end

  rrsa_pick #(
    .NUM_SERVERS (NUM_SERVERS),
    .IDX_W       (IDX_W)
  ) u_pick (
    .free_i   (free),
    .pref_i   (pref_eff),
    .found_o  (found),
    .onehot_o (pick_oh),
    .idx_o    (pick_idx)
  );

  assign finish_new = FINISH_W'(s1_time_r) + FINISH_W'(s1_load_r);
  assign cnt_sel    = count_r[pick_idx];
  // saturating increment
  assign cnt_bump   = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + COUNT_W'(1);

  // only the chosen server's timer and count change
  always_comb begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      finish_nxt[s] = finish_r[s];
      count_nxt[s]  = count_r[s];
      if (alloc_fire && found && pick_oh[s]) begin
        finish_nxt[s] = finish_new;
        count_nxt[s]  = cnt_bump;
      end
    end
  end

  // busiest figures are taken from the counts after the request in the
  // allocation result register, which is always the latest update
  rrsa_busiest #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_busiest (
    .count_i  (count_r),
    .in_use_i (in_use),
    .best_o   (best),
    .mask_o   (best_mask)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srv_cfg_r <= CFG_RESET;
      pref_r    <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      for (int s = 0; s < NUM_SERVERS; s++) begin
        finish_r[s] <= '0;
        count_r[s]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        srv_cfg_r <= cfg_wr_data;
      end
      if (alloc_fire) begin
        pref_r <= pref_nxt;
      end
      for (int s = 0; s < NUM_SERVERS; s++) begin
        finish_r[s] <= finish_nxt[s];
        count_r[s]  <= count_nxt[s];
      end
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_time_r <= in_arrival_time;
      s1_load_r <= in_service_load;
    end
    if (alloc_fire) begin
      s2_drop_r <= !found;
      s2_srv_r  <= found ? SRV_W'(pick_idx) : '0;
      s2_cnt_r  <= found ? cnt_bump : '0;
    end
    if (out_adv && s2_v_r) begin
      out_drop_r <= s2_drop_r;
      out_srv_r  <= s2_srv_r;
      out_cnt_r  <= s2_cnt_r;
      out_best_r <= best;
      out_mask_r <= best_mask;
    end
  end

  assign out_valid           = out_v_r;
  assign out_dropped         = out_drop_r;
  assign out_assigned_server = out_srv_r;
  assign out_assigned_count  = out_cnt_r;
  assign out_busiest_count   = out_best_r;
  assign out_busiest_mask    = out_mask_r;

  // the chosen server is always inside the rotation
  a_pick_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (alloc_fire && found) |-> (KW'(pick_idx) < k_n))
    else $error("picked server outside the rotation");

  // the rotation pointer moves on after every request when more than one server
  a_pref_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (alloc_fire && (k_n > KW'(1)) && !cfg_wr_en) |=> (pref_r != $past(pref_r)))
    else $error("rotation pointer did not advance");

  // a served request leaves a nonzero count that cannot exceed the busiest one
  a_count_vs_best: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dropped) |->
      ((out_assigned_count != '0) && (out_busiest_count >= out_assigned_count)))
    else $error("assigned count inconsistent with busiest count");

  // a dropped request reports no server and no count
  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> ((out_assigned_server == '0) && (out_assigned_count == '0)))
    else $error("dropped request carries an assignment");

endmodule

`default_nettype wire

### src/rrsa_pick.sv
`default_nettype none

module rrsa_pick #(
  parameter int unsigned NUM_SERVERS = 16,
  parameter int unsigned IDX_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1
) (
  input  wire logic [NUM_SERVERS-1:0] free_i,
  input  wire logic [IDX_W-1:0]       pref_i,
  output logic                        found_o,
  output logic [NUM_SERVERS-1:0]      onehot_o,
  output logic [IDX_W-1:0]            idx_o
);

  logic [NUM_SERVERS-1:0] at_or_above;
  logic [NUM_SERVERS-1:0] upper;
  logic [NUM_SERVERS-1:0] cand;

  // servers at or above the preferred one
  always_comb begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      at_or_above[s] = (IDX_W'(s) >= pref_i);
    end
  end

  assign upper   = free_i & at_or_above;
  // wrap to the lowest free server when nothing above is free
  assign cand    = (|upper) ? upper : free_i;
  assign found_o = |free_i;
  // isolate the lowest set bit
  assign onehot_o = cand & (~cand + NUM_SERVERS'(1));

  always_comb begin
    idx_o = '0;
    for (int s = 0; s < NUM_SERVERS; s++) begin
      if (onehot_o[s]) begin
        idx_o = idx_o | IDX_W'(s);
      end
    end
  end

endmodule

`default_nettype wire

### src/rrsa_busiest.sv
`default_nettype none

module rrsa_busiest #(
  parameter int unsigned NUM_SERVERS = 16
) (
  input  wire logic [rrsa_pkg::COUNT_W-1:0] count_i [NUM_SERVERS],
  input  wire logic [NUM_SERVERS-1:0]       in_use_i,
  output logic [rrsa_pkg::COUNT_W-1:0]      best_o,
  output logic [rrsa_pkg::MASK_W-1:0]       mask_o
);

  import rrsa_pkg::*;

  localparam int unsigned LVLS = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 0;
  localparam int unsigned LEAVES = 1 << LVLS;

  logic [COUNT_W-1:0]     tree [LVLS+1][LEAVES];
  logic [NUM_SERVERS-1:0] hit;

  // pairwise max tree, servers out of use count as zero
  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        tree[l][i] = '0;
      end
    end
    for (int i = 0; i < NUM_SERVERS; i++) begin
      tree[0][i] = in_use_i[i] ? count_i[i] : '0;
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        tree[l+1][i] = (tree[l][2*i] > tree[l][2*i+1]) ? tree[l][2*i] : tree[l][2*i+1];
      end
    end
  end

  assign best_o = tree[LVLS][0];

  always_comb begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      hit[s] = in_use_i[s] && (count_i[s] == best_o);
    end
  end

  assign mask_o = MASK_W'(hit);

endmodule

`default_nettype wire

### dv/server_allocation_checker.sv
`timescale 1ns / 100ps

module server_allocation_checker #(
  parameter int unsigned NUM_SERVERS = rrsa_pkg::NUM_SERVERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rrsa_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rrsa_pkg::TIME_W-1:0]  in_arrival_time,
  input  logic [rrsa_pkg::LOAD_W-1:0]  in_service_load,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_dropped,
  input  logic [rrsa_pkg::SRV_W-1:0]   out_assigned_server,
  input  logic [rrsa_pkg::COUNT_W-1:0] out_assigned_count,
  input  logic [rrsa_pkg::COUNT_W-1:0] out_busiest_count,
  input  logic [rrsa_pkg::MASK_W-1:0]  out_busiest_mask,
  output int                           grants_outstanding,
  output int                           mismatch_count
);

  import rrsa_pkg::*;

  typedef struct packed {
    logic               dropped;
    logic [SRV_W-1:0]   server;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] busiest;
    logic [MASK_W-1:0]  mask;
  } grant_t;

  grant_t              expected_grants[$];
  logic [FINISH_W-1:0] finish_at [NUM_SERVERS];
  logic [COUNT_W-1:0]  served [NUM_SERVERS];
  int unsigned         next_pref;
  logic [CFG_W-1:0]    servers_cfg;

  function automatic grant_t allocate_request(input logic [TIME_W-1:0] now,
                                              input logic [LOAD_W-1:0] load);
    int unsigned k;
    int unsigned pref;
    int          pick_hi;
    int          pick_lo;
    int          pick;
    grant_t      g;
    k = servers_cfg;
    if (k == 0) k = 1;
    if (k > NUM_SERVERS) k = NUM_SERVERS;
    pref = (next_pref < k) ? next_pref : 0;
    pick_hi = -1;
    pick_lo = -1;
    for (int s = 0; s < k; s++) begin
      if (finish_at[s] <= FINISH_W'(now)) begin
        if (pick_lo < 0) pick_lo = s;
        if (pick_hi < 0 && s >= pref) pick_hi = s;
      end
    end
    pick = (pick_hi >= 0) ? pick_hi : pick_lo;
    next_pref = (pref + 1 >= k) ? 0 : pref + 1;
    g = '0;
    if (pick >= 0) begin
      finish_at[pick] = FINISH_W'(now) + FINISH_W'(load);
      if (served[pick] != COUNT_MAX) served[pick] = served[pick] + 1'b1;
      g.server = SRV_W'(pick);
      g.count  = served[pick];
    end else begin
      g.dropped = 1'b1;
    end
    for (int s = 0; s < k; s++)
      if (served[s] > g.busiest) g.busiest = served[s];
    for (int s = 0; s < k && s < MASK_W; s++)
      if (served[s] == g.busiest) g.mask[s] = 1'b1;
    return g;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    grant_t fresh;
    if (!rst_n) begin
      for (int s = 0; s < NUM_SERVERS; s++) begin
        finish_at[s] = '0;
        served[s]    = '0;
      end
      next_pref      = 0;
      servers_cfg    = CFG_RESET;
      mismatch_count = 0;
      expected_grants.delete();
    end else begin
      if (cfg_wr_en) servers_cfg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        fresh = allocate_request(in_arrival_time, in_service_load);
        expected_grants = {expected_grants, fresh};
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $error("result with no request waiting");
          mismatch_count++;
        end else begin
          want = expected_grants.pop_front();
          check_field("dropped", want.dropped, out_dropped);
          check_field("assigned_server", want.server, out_assigned_server);
          check_field("assigned_count", want.count, out_assigned_count);
          check_field("busiest_count", want.busiest, out_busiest_count);
          check_field("busiest_mask", want.mask, out_busiest_mask);
        end
      end
    end
    grants_outstanding <= expected_grants.size();
  end

endmodule

### dv/tb_round_robin_server_allocator.sv
`timescale 1ns / 100ps

module tb_round_robin_server_allocator;

  import rrsa_pkg::*;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 200_000;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [TIME_W-1:0]  in_arrival_time;
  logic [LOAD_W-1:0]  in_service_load;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_dropped;
  logic [SRV_W-1:0]   out_assigned_server;
  logic [COUNT_W-1:0] out_assigned_count;
  logic [COUNT_W-1:0] out_busiest_count;
  logic [MASK_W-1:0]  out_busiest_mask;

  int                 grants_outstanding;
  int                 mismatch_count;
  int                 cycle_count = 0;

  // idle percentages for the two sides, changed as the run goes on
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;

  // running arrival clock of the random requests
  logic [TIME_W-1:0]  now_base;

  // pool sizes per random phase: reset value, one, zero, clipped, odd sizes
  int unsigned        pool_sizes [10] = '{16, 1, 0, 31, 5, 17, 3, 0, 2, 16};

  round_robin_server_allocator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arrival_time     (in_arrival_time),
    .in_service_load     (in_service_load),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dropped         (out_dropped),
    .out_assigned_server (out_assigned_server),
    .out_assigned_count  (out_assigned_count),
    .out_busiest_count   (out_busiest_count),
    .out_busiest_mask    (out_busiest_mask)
  );

  // watches both channels and the register port, predicts every grant
  server_allocation_checker grant_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arrival_time     (in_arrival_time),
    .in_service_load     (in_service_load),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dropped         (out_dropped),
    .out_assigned_server (out_assigned_server),
    .out_assigned_count  (out_assigned_count),
    .out_busiest_count   (out_busiest_count),
    .out_busiest_mask    (out_busiest_mask),
    .grants_outstanding  (grants_outstanding),
    .mismatch_count      (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one request and hold it until taken; valid stays high between
  // back-to-back requests and only drops during an idle gap
  task automatic send_request(input logic [TIME_W-1:0] arrival,
                              input logic [LOAD_W-1:0] load);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_arrival_time <= arrival;
    in_service_load <= load;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every predicted grant is back and the pipe has emptied
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_outstanding != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // register writes only ever happen with the block idle
  task automatic set_server_count(input logic [CFG_W-1:0] count);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly a slowly advancing clock with short loads so that servers fill
  // up and free again; now and then a jump, a late-stamped request or a
  // long load
  task automatic random_request();
    logic [TIME_W-1:0] arrival;
    logic [LOAD_W-1:0] load;
    int unsigned       roll;
    roll = $urandom_range(99);
    if (roll < 2) now_base = now_base + TIME_W'($urandom_range(1, 1 << 20));
    else          now_base = now_base + TIME_W'($urandom_range(0, 3));
    arrival = now_base;
    // arrival stamped earlier than the previous request
    if (roll >= 96) arrival = now_base - TIME_W'($urandom_range(1, 32));
    roll = $urandom_range(99);
    if (roll < 90)      load = LOAD_W'($urandom_range(1, 48));
    else if (roll < 97) load = LOAD_W'($urandom_range(1, 1000));
    else                load = LOAD_W'($urandom_range(1, 65535));
    send_request(arrival, load);
  endtask

  initial begin
    int item;
    in_valid        = 1'b0;
    in_arrival_time = '0;
    in_service_load = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 30;
    recv_stall_pct  = 88;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // full pool after reset, rotation starts at server 0, earliest time
    send_request(0, 1);
    send_request(0, 1);
    send_request(0, 1);
    repeat (5) send_request(1, 3);
    // rotation pointer sits at 8: shrinking the pool leaves it stale,
    // so the next request falls back to server 0
    set_server_count(4);
    repeat (4) send_request(4, 10);
    // all four servers busy: request dropped, pointer still moves
    send_request(5, 10);
    send_request(14, 1);
    send_request(14, 1);
    // a zero server count behaves as a single server
    set_server_count(0);
    send_request(20, 1);
    send_request(20, 1);
    send_request(21, 1);
    // counts beyond the pool are clipped to the full sixteen
    set_server_count(31);
    repeat (3) send_request(30, 2);

    // --- random part ---
    now_base = 40;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 7) set_server_count(CFG_W'($urandom_range(0, 31)));
      else            set_server_count(CFG_W'(pool_sizes[phase]));
      for (int i = 0; i < 150; i++) begin
        item = phase * 150 + i;
        // swap the idling sides, then run flat out
        if (item == 500) begin
          send_idle_pct  = 88;
          recv_stall_pct = 30;
        end
        if (item == 1000) begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        // sender holds back until every grant has come home
        if (item == 750) wait_for_results();
        random_request();
      end
    end

    // --- extremes of time and load, last since they pin servers busy ---
    set_server_count(16);
    send_request('1, '1);
    repeat (6) send_request(TIME_W'($urandom), LOAD_W'($urandom_range(1, 1073741823)));
    repeat (3) send_request('1, 1);

    wait_for_results();
    if (mismatch_count == 0 && grants_outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
src/rrsa_pkg.sv
src/rrsa_pick.sv
src/rrsa_busiest.sv
src/round_robin_server_allocator.sv
dv/server_allocation_checker.sv
dv/tb_round_robin_server_allocator.sv
